/* hw/rtl/stepper_ramp_interval_generator_top_defines.svh */
// Assertion macros used by the ramp generator top level
`ifndef STEPPER_RAMP_INTERVAL_GENERATOR_TOP_DEFINES_SVH
`define STEPPER_RAMP_INTERVAL_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRIG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRIG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/srig_pkg.sv */
// Shared types, constants and helpers for the stepper ramp interval generator
package srig_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int INTERVAL_W    = 31;
    localparam int TIMER_W       = 23;
    localparam int RAMP_W        = 24;
    localparam int EDGE_W        = 17;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int DIVIDEND_W    = 32;
    localparam int DIVISOR_W     = RAMP_W + 2;
    localparam int DIV_CNT_W     = 5;

    localparam logic [CFG_W-1:0] SPR_RESET = 16'd3200;
    localparam logic [CFG_W-1:0] NDS_RESET = 16'd2600;
    localparam logic [RAMP_W-1:0] RAMP_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_DOWN     = 2'd1;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CMD  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ACC,
        OP_DEC,
        OP_DEC_ZERO
    } op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [TIMER_W-1:0] to_timer(input logic [INTERVAL_W-1:0] iv);
        logic [INTERVAL_W-1:0] shifted;
        shifted = iv >> FRAC_BITS;
        return shifted[TIMER_W-1:0];
    endfunction

endpackage

/* hw/rtl/stepper_ramp_interval_generator_top.sv */
// Top level: step interval ramp generator for a needle stepper drive
//
// Input channel (in_valid/in_ready) takes either a speed command (mode 1) or a
// step tick (mode 0). Every transfer gives exactly one result on the output
// channel (out_valid/out_ready): next timer reload, step level, revolution
// pulse, needle-down flag and run flag.
// Commands and ticks while stopped load the result directly; it is valid in the
// cycle after the transfer. A running tick that needs division uses one shared
// restoring divider (2c/(4n+1) when speeding up, 2c/(4n-1) when slowing down),
// one quotient bit a cycle; the result is loaded after the divider is done, and
// no new tick is taken before that. Ticks that need no division skip it.
// in_ready is low while a tick is being worked on and while a result waits
// that the receiver is not taking this cycle; a stalled receiver holds the
// result register and so stalls the input.
// Reset clears the interval, target, ramp and edge counters and the run flag;
// steps_per_rev resets to 3200, needle_down_steps to 2600. Registers are written
// via cfg_we/cfg_index/cfg_data, by the user only while idle; not enforced.
`include "stepper_ramp_interval_generator_top_defines.svh"

module stepper_ramp_interval_generator_top
    import srig_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [INTERVAL_W-1:0] target_interval,
    input  logic [INTERVAL_W-1:0] start_interval,
    input  logic                  load_start,
    input  logic                  stop_at_target,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TIMER_W-1:0]    timer_interval,
    output logic                  step_level,
    output logic                  revolution_done,
    output logic                  needle_down,
    output logic                  running,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    op_t                   op_sel;
    logic [CFG_W-1:0]      spr_reg, nds_reg;
    logic [INTERVAL_W-1:0] cur_reg, cur_next;
    logic [INTERVAL_W-1:0] tgt_reg, tgt_next;
    logic [RAMP_W-1:0]     ramp_reg, ramp_next;
    logic [EDGE_W-1:0]     edge_reg, edge_next;
    logic                  stop_reg, stop_next;
    logic                  pin_reg, pin_next;
    logic                  run_reg, run_next;
    logic                  rev_reg, rev_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic [INTERVAL_W-1:0] out_interval;
    logic                  out_level, out_rev, out_run;
    logic [TIMER_W-1:0]    timer_reg;
    logic                  level_reg, revd_reg, needle_reg, running_reg;

    logic                  div_start;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] div_quotient;
    div_status_t           div_status;

    logic                  in_fire, out_free;
    logic [EDGE_W:0]       edge_inc, edge_limit;
    logic [EDGE_W-1:0]     spr_ext;
    logic [CFG_W-1:0]      span;
    logic                  decel_win;
    logic [RAMP_W-1:0]     ramp_inc;
    logic [DIVIDEND_W-1:0] dec_amt, cur_ext, acc_diff;
    logic [DIVIDEND_W:0]   nx;
    logic [INTERVAL_W-1:0] acc_res, cur_new;
    logic                  reached, stop_hit, ramp_dec;
    logic                  needle_now;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    // edge counter and deceleration window, from the count before the tick
    assign spr_ext    = {1'b0, spr_reg};
    assign edge_inc   = {1'b0, edge_reg} + 1'b1;
    assign edge_limit = {1'b0, spr_reg, 1'b0};
    assign span       = spr_reg - edge_reg[CFG_W-1:0];
    assign decel_win  = (edge_reg <= spr_ext) && ({{(RAMP_W-CFG_W){1'b0}}, span} <= ramp_reg);
    assign ramp_inc   = (ramp_reg == RAMP_MAX) ? ramp_reg : ramp_reg + 1'b1;
    assign needle_now = edge_reg >= {nds_reg, 1'b0};

    always_comb
    begin
        if (cur_reg > tgt_reg)
            op_sel = OP_ACC;
        else if (cur_reg < tgt_reg && decel_win)
            op_sel = (ramp_reg != '0) ? OP_DEC : OP_DEC_ZERO;
        else
            op_sel = OP_NONE;
    end

    // ramp arithmetic on the quotient
    assign cur_ext  = {1'b0, cur_reg};
    assign dec_amt  = (div_quotient == '0) ? DIVIDEND_W'(1) : div_quotient;
    assign acc_diff = cur_ext - dec_amt;
    assign acc_res  = (dec_amt >= cur_ext || acc_diff <= {1'b0, tgt_reg})
                      ? tgt_reg : acc_diff[INTERVAL_W-1:0];
    assign nx       = {1'b0, cur_ext} + {1'b0, div_quotient};

    always_comb
    begin
        reached  = 1'b0;
        ramp_dec = 1'b0;
        cur_new  = cur_reg;
        case (op_reg)
            OP_ACC:
            begin
                cur_new = acc_res;
            end
            OP_DEC:
            begin
                if (nx < {2'b00, tgt_reg})
                begin
                    cur_new  = nx[INTERVAL_W-1:0];
                    ramp_dec = 1'b1;
                end
                else
                begin
                    reached = 1'b1;
                end
            end
            OP_DEC_ZERO:
            begin
                reached = 1'b1;
            end
            default:
            begin
                cur_new = cur_reg;
            end
        endcase
        stop_hit = reached && stop_reg;
        if (reached)
        begin
            cur_new = tgt_reg;
            if (!stop_reg && op_reg == OP_DEC)
                ramp_dec = 1'b1;
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && mode == MODE_TICK && run_reg)
                begin
                    if (op_sel == OP_ACC || op_sel == OP_DEC)
                        state_next = ST_DIV;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer: datapath and result
    always_comb
    begin
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        ramp_next      = ramp_reg;
        edge_next      = edge_reg;
        stop_next      = stop_reg;
        pin_next       = pin_reg;
        run_next       = run_reg;
        rev_next       = rev_reg;
        op_next        = op_reg;
        div_start      = 1'b0;
        div_divisor    = {ramp_inc, 2'b01};
        out_load       = 1'b0;
        out_interval   = cur_reg;
        out_level      = pin_reg;
        out_rev        = 1'b0;
        out_run        = run_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode == MODE_CMD)
                    begin
                        tgt_next  = target_interval;
                        stop_next = stop_at_target;
                        run_next  = 1'b1;
                        if (load_start)
                            cur_next = start_interval;
                        out_load     = 1'b1;
                        out_interval = load_start ? start_interval : cur_reg;
                        out_run      = 1'b1;
                    end
                    else if (!run_reg)
                    begin
                        out_load = 1'b1;
                    end
                    else
                    begin
                        pin_next = !pin_reg;
                        if (edge_inc > edge_limit)
                        begin
                            edge_next = '0;
                            rev_next  = 1'b1;
                        end
                        else
                        begin
                            edge_next = edge_inc[EDGE_W-1:0];
                            rev_next  = 1'b0;
                        end
                        op_next = op_sel;
                        if (op_sel == OP_ACC)
                        begin
                            ramp_next   = ramp_inc;
                            div_start   = 1'b1;
                            div_divisor = {ramp_inc, 2'b01};
                        end
                        else if (op_sel == OP_DEC)
                        begin
                            // 4n - 1 with n >= 1
                            div_start   = 1'b1;
                            div_divisor = {ramp_reg - 1'b1, 2'b11};
                        end
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    out_level = pin_reg;
                    out_rev   = rev_reg;
                    if (ramp_dec)
                        ramp_next = ramp_reg - 1'b1;
                    if (stop_hit)
                    begin
                        cur_next     = '0;
                        stop_next    = 1'b0;
                        run_next     = 1'b0;
                        out_interval = tgt_reg;
                        out_run      = 1'b0;
                    end
                    else
                    begin
                        cur_next     = cur_new;
                        run_next     = (cur_new == '0) ? 1'b0 : run_reg;
                        out_interval = cur_new;
                        out_run      = (cur_new == '0) ? 1'b0 : run_reg;
                    end
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
        if (out_load)
            out_valid_next = 1'b1;
    end

    srig_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({cur_reg, 1'b0}),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NONE;
            spr_reg       <= SPR_RESET;
            nds_reg       <= NDS_RESET;
            cur_reg       <= '0;
            tgt_reg       <= '0;
            ramp_reg      <= '0;
            edge_reg      <= '0;
            stop_reg      <= 1'b0;
            pin_reg       <= 1'b0;
            run_reg       <= 1'b0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cur_reg       <= cur_next;
            tgt_reg       <= tgt_next;
            ramp_reg      <= ramp_next;
            edge_reg      <= edge_next;
            stop_reg      <= stop_next;
            pin_reg       <= pin_next;
            run_reg       <= run_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEPS_PER_REV: spr_reg <= cfg_data;
                    CFG_NEEDLE_DOWN:   nds_reg <= cfg_data;
                    default:           spr_reg <= spr_reg;
                endcase
            end
        end
    end

    // result register; needle flag taken from the edge count after the tick
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            timer_reg   <= to_timer(out_interval);
            level_reg   <= out_level;
            revd_reg    <= out_rev;
            running_reg <= out_run;
            needle_reg  <= (state_reg == ST_FIN) ? needle_now
                           : (edge_reg >= {nds_reg, 1'b0});
        end
    end

    assign out_valid       = out_valid_reg;
    assign timer_interval  = timer_reg;
    assign step_level      = level_reg;
    assign revolution_done = revd_reg;
    assign needle_down     = needle_reg;
    assign running         = running_reg;

    `SRIG_ASSERT_NOW(a_div_active, state_reg == ST_DIV,
        div_status.busy || div_status.done, "divider idle while sequencer waits on it")
    `SRIG_ASSERT_NEXT(a_div_to_fin, state_reg == ST_DIV && div_status.done,
        state_reg == ST_FIN, "quotient ready but sequencer did not finish")
    `SRIG_ASSERT_NOW(a_start_idle, div_start,
        state_reg == ST_IDLE && !div_status.busy, "divider started while busy")
    `SRIG_ASSERT_NOW(a_acc_count, state_reg == ST_FIN && op_reg == OP_ACC,
        ramp_reg != '0, "ramp count zero after speed-up step")

endmodule

/* hw/rtl/srig_div.sv */
// Restoring divider, one quotient bit per cycle
module srig_div
    import srig_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output div_status_t           status
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
